// ===== rtl/core/grct_pkg.sv =====
// ----------------------------------------------------------------------------
// grct_pkg
// Shared types, constants and helpers of the 2D grid ray cell traversal block.
// ----------------------------------------------------------------------------
package grct_pkg;

  // Geometry and fixed-point formats
  localparam int CELL_BITS       = 16;
  localparam int POINT_FRAC_BITS = 16;
  localparam int T_FRAC_BITS     = 30;
  localparam int T_BITS          = T_FRAC_BITS + 2;

  // Divider operand formats
  localparam int NUM_BITS = POINT_FRAC_BITS + 1;
  localparam int NUM_SH   = (T_FRAC_BITS >= POINT_FRAC_BITS) ?
                            (T_FRAC_BITS - POINT_FRAC_BITS) : 0;
  localparam int MAG_SH   = (T_FRAC_BITS >= POINT_FRAC_BITS) ?
                            0 : (POINT_FRAC_BITS - T_FRAC_BITS);
  localparam int DVD_BITS = NUM_BITS + NUM_SH;
  localparam int DVS_BITS = CELL_BITS + MAG_SH;
  localparam int SAT_BITS = (DVD_BITS > T_BITS) ? DVD_BITS : T_BITS;
  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  localparam logic [T_BITS-1:0]   T_MAX   = {T_BITS{1'b1}};
  localparam logic [NUM_BITS-1:0] NUM_ONE = {1'b1, {POINT_FRAC_BITS{1'b0}}};

  // Command codes
  localparam logic CMD_SETUP = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Step sign codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic               command;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic               more;
  } out_req_t;

  // Divider command and response
  typedef struct packed {
    logic                start;
    logic [DVD_BITS-1:0] dividend;
    logic [DVS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DVD_BITS-1:0] quotient;
  } div_rsp_t;

  // Floor of a signed point coordinate, wrapped to the cell width
  function automatic logic [CELL_BITS-1:0] cell_of(input logic signed [31:0] raw);
    logic signed [31:0] sh;
    sh = raw >>> POINT_FRAC_BITS;
    return sh[CELL_BITS-1:0];
  endfunction

  // Cell to the 16-bit output field (sign-extended or truncated)
  function automatic logic [15:0] cell_out(input logic [CELL_BITS-1:0] pos);
    logic signed [31:0] w;
    w = 32'($signed(pos));
    return w[15:0];
  endfunction

  // Quotient clamped to the parameter format
  function automatic logic [T_BITS-1:0] sat_quo(input logic [DVD_BITS-1:0] q);
    logic [SAT_BITS-1:0] qe;
    qe = SAT_BITS'(q);
    if (qe > SAT_BITS'(T_MAX)) begin
      return T_MAX;
    end
    return qe[T_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/grct_div.sv =====
// ----------------------------------------------------------------------------
// grct_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grct_div (
  input  logic               clk,
  input  logic               rst,
  input  grct_pkg::div_req_t req,
  output grct_pkg::div_rsp_t rsp
);
  import grct_pkg::*;

  logic [DVD_BITS-1:0] quo;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS-1:0] rem;
  logic [CNT_BITS-1:0] cnt;
  logic                run;
  logic                done;

  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   rem_sub;
  logic                take;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh  = {rem, quo[DVD_BITS-1]};
    take    = (rem_sh >= {1'b0, dvs});
    rem_sub = take ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= CNT_BITS'(DVD_BITS);
        run <= 1'b1;
      end else if (run) begin
        rem <= rem_sub[DVS_BITS-1:0];
        quo <= {quo[DVD_BITS-2:0], take};
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/grid_ray_cell_traversal_2d_top.sv =====
// ----------------------------------------------------------------------------
// grid_ray_cell_traversal_2d_top
// Walks the grid cells crossed by a 2D segment, one cell per step request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_req): a setup request carries the
//   segment start and end in signed Q16.16; a step request ignores them.
//   Output channel (out_valid / out_stall / out_req): one response per
//   request with the current cell and the "more" flag.
// Request flow:
//   A step request does the compare and saturating add of the
//   boundary parameters in the accept cycle, then the output load.
//   A setup request computes four quotients through one shared bit-serial
//   divider; an axis with no cell delta skips its two divisions.
//   in_stall is high while a request is in progress.
// Reset:
//   Synchronous rst clears the traversal state to cell (0,0) at its goal, so
//   a step before any setup reports (0,0) with more clear.
// Back-pressure:
//   The response register holds while out_stall is high; a finished request
//   waits for it and the block takes no new request meanwhile.
// ----------------------------------------------------------------------------
module grid_ray_cell_traversal_2d_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  grct_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output grct_pkg::out_req_t out_req
);
  import grct_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_ISSUE,
    ST_WAIT,
    ST_RESULT
  } state_t;

  // Division job order
  localparam logic [1:0] JOB_NEXT_X = 2'd0;
  localparam logic [1:0] JOB_GAP_X  = 2'd1;
  localparam logic [1:0] JOB_NEXT_Y = 2'd2;
  localparam logic [1:0] JOB_GAP_Y  = 2'd3;

  state_t state;

  // Traversal state
  logic [CELL_BITS-1:0] pos_x, pos_y, goal_x, goal_y;
  logic [1:0]           dir_x, dir_y;
  logic [T_BITS-1:0]    next_cross_x, next_cross_y, cross_gap_x, cross_gap_y;

  // Setup working registers
  logic [POINT_FRAC_BITS-1:0] frac_x, frac_y;
  logic [CELL_BITS-1:0]       mag_x, mag_y;
  logic [1:0]                 job;
  out_req_t                   res;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    out_free;
  logic                    in_take;
  logic                    at_goal;
  logic                    move_x;
  logic [T_BITS:0]         sum_x, sum_y;
  logic [T_BITS-1:0]       sat_x, sat_y;
  logic signed [CELL_BITS:0] d_x, d_y;
  logic signed [CELL_BITS:0] a_x, a_y;
  logic [1:0]              job_dir;
  logic [POINT_FRAC_BITS-1:0] job_frac;
  logic [CELL_BITS-1:0]    job_mag;
  logic [NUM_BITS-1:0]     job_num;
  logic [T_BITS-1:0]       job_val;

  grct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Step: goal test, axis choice and saturating parameter update
  always_comb begin
    at_goal = (pos_x == goal_x) && (pos_y == goal_y);
    move_x  = (next_cross_x < next_cross_y);
    sum_x   = {1'b0, next_cross_x} + {1'b0, cross_gap_x};
    sum_y   = {1'b0, next_cross_y} + {1'b0, cross_gap_y};
    sat_x   = sum_x[T_BITS] ? T_MAX : sum_x[T_BITS-1:0];
    sat_y   = sum_y[T_BITS] ? T_MAX : sum_y[T_BITS-1:0];
  end

  // Setup: signed cell deltas and magnitudes
  always_comb begin
    d_x = $signed({goal_x[CELL_BITS-1], goal_x}) - $signed({pos_x[CELL_BITS-1], pos_x});
    d_y = $signed({goal_y[CELL_BITS-1], goal_y}) - $signed({pos_y[CELL_BITS-1], pos_y});
    a_x = d_x[CELL_BITS] ? -d_x : d_x;
    a_y = d_y[CELL_BITS] ? -d_y : d_y;
  end

  // Division job operands
  always_comb begin
    job_dir  = job[1] ? dir_y  : dir_x;
    job_frac = job[1] ? frac_y : frac_x;
    job_mag  = job[1] ? mag_y  : mag_x;
    if (job[0]) begin
      job_num = NUM_ONE;
    end else if (job_dir == DIR_POS) begin
      job_num = NUM_ONE - {1'b0, job_frac};
    end else begin
      job_num = (job_frac != '0) ? {1'b0, job_frac} : NUM_ONE;
    end
    job_val          = (state == ST_WAIT) ? sat_quo(div_rsp.quotient) : T_MAX;
    div_req.start    = (state == ST_ISSUE) && (job_dir != DIR_NONE);
    div_req.dividend = DVD_BITS'(job_num) << NUM_SH;
    div_req.divisor  = DVS_BITS'(job_mag) << MAG_SH;
  end

  // Sequencer, traversal state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      job          <= JOB_NEXT_X;
      pos_x        <= '0;
      pos_y        <= '0;
      goal_x       <= '0;
      goal_y       <= '0;
      dir_x        <= DIR_NONE;
      dir_y        <= DIR_NONE;
      next_cross_x <= '0;
      next_cross_y <= '0;
      cross_gap_x  <= '0;
      cross_gap_y  <= '0;
    end else begin
      // response taken; a fresh one in ST_RESULT reloads the register instead
      if (out_valid && !out_stall && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (in_req.command == CMD_STEP) begin
              res.cell_x <= cell_out(pos_x);
              res.cell_y <= cell_out(pos_y);
              res.more   <= !at_goal;
              if (!at_goal) begin
                if (move_x) begin
                  pos_x        <= pos_x + {{(CELL_BITS-2){dir_x[1]}}, dir_x};
                  next_cross_x <= sat_x;
                end else begin
                  pos_y        <= pos_y + {{(CELL_BITS-2){dir_y[1]}}, dir_y};
                  next_cross_y <= sat_y;
                end
              end
              state <= ST_RESULT;
            end else begin
              pos_x  <= cell_of(in_req.start_x);
              pos_y  <= cell_of(in_req.start_y);
              goal_x <= cell_of(in_req.end_x);
              goal_y <= cell_of(in_req.end_y);
              frac_x <= in_req.start_x[POINT_FRAC_BITS-1:0];
              frac_y <= in_req.start_y[POINT_FRAC_BITS-1:0];
              state  <= ST_DELTA;
            end
          end
        end
        ST_DELTA: begin
          mag_x      <= a_x[CELL_BITS-1:0];
          mag_y      <= a_y[CELL_BITS-1:0];
          dir_x      <= (d_x == '0) ? DIR_NONE : (d_x[CELL_BITS] ? DIR_NEG : DIR_POS);
          dir_y      <= (d_y == '0) ? DIR_NONE : (d_y[CELL_BITS] ? DIR_NEG : DIR_POS);
          res.cell_x <= cell_out(pos_x);
          res.cell_y <= cell_out(pos_y);
          res.more   <= (d_x != '0) || (d_y != '0);
          job        <= JOB_NEXT_X;
          state      <= ST_ISSUE;
        end
        ST_ISSUE, ST_WAIT: begin
          if ((state == ST_WAIT && div_rsp.done) ||
              (state == ST_ISSUE && job_dir == DIR_NONE)) begin
            case (job)
              JOB_NEXT_X: next_cross_x <= job_val;
              JOB_GAP_X:  cross_gap_x  <= job_val;
              JOB_NEXT_Y: next_cross_y <= job_val;
              JOB_GAP_Y:  cross_gap_y  <= job_val;
              default:    cross_gap_y  <= job_val;
            endcase
            job   <= job + 2'd1;
            state <= (job == JOB_GAP_Y) ? ST_RESULT : ST_ISSUE;
          end else if (state == ST_ISSUE) begin
            state <= ST_WAIT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_req   <= res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
